### sv/modbus_rtu_frame_receiver_unit_defines.svh
// ---------------------------------------------------------------------------
// modbus rtu frame receiver assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MRFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mrfr_pkg.sv
// ---------------------------------------------------------------------------
// mrfr_pkg
// types, codes and the crc step shared by the modbus rtu receiver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrfr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_REQ  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       node_ok;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_RECV      = 4'd1,
    ST_OVF       = 4'd2,
    ST_REQ_OK    = 4'd3,
    ST_ILL_FN    = 4'd4,
    ST_REPLY_OK  = 4'd5,
    ST_REPLY_ERR = 4'd6,
    ST_CRC_BAD   = 4'd7,
    ST_BAD_LEN   = 4'd8,
    ST_ACCEPT    = 4'd9,
    ST_REFUSE    = 4'd10
  } status_t;

  localparam logic [1:0] CFG_OWN_ADDR      = 2'd0;
  localparam logic [1:0] CFG_SILENCE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_REPLY_TIMEOUT = 2'd2;

  localparam logic [7:0]  OWN_ADDR_RST      = 8'd1;
  localparam logic [15:0] SILENCE_LIMIT_RST = 16'd750;
  localparam logic [31:0] REPLY_TIMEOUT_RST = 32'd1000000;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_READ_INPUT   = 8'h04;

  localparam logic [7:0] NODE_BROADCAST = 8'h00;
  localparam logic [7:0] NODE_RESERVED  = 8'hFF;

  localparam int HDR_BYTES = 6;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/mrfr_front.sv
// ---------------------------------------------------------------------------
// mrfr_front
// accepts input items, classifies them and queues them for the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrfr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_kind,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic [7:0]    in_target_node,
  output logic               q_valid,
  output mrfr_pkg::item_t    q_item,
  input  wire logic          q_pop
);
  import mrfr_pkg::*;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  item_t              slot_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  item_t              item_in;
  logic               push;

  // classify
  always_comb begin
    item_in.op      = op_t'(in_kind);
    item_in.data    = (op_t'(in_kind) == OP_REQ) ? in_target_node : in_rx_byte;
    item_in.node_ok = (in_target_node != NODE_BROADCAST) && (in_target_node != NODE_RESERVED);
  end

  assign in_tready = (cnt_r != CNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

### sv/mrfr_back.sv
// ---------------------------------------------------------------------------
// mrfr_back
// frame assembly, crc check, timers and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrfr_back #(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_wdata,
  input  wire logic          q_valid,
  input  wire mrfr_pkg::item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mrfr_pkg::status_t  out_status,
  output logic [15:0]        out_start_register,
  output logic [15:0]        out_register_count,
  output logic [7:0]         out_function_code
);
  import mrfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [7:0]       own_addr_r;
  logic [15:0]      sil_limit_r;
  logic [31:0]      timeout_r;

  logic             in_frame_r, in_frame_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      sil_r, sil_nxt;
  logic [7:0]       awaited_r, awaited_nxt;
  logic [31:0]      wait_r, wait_nxt;
  logic [7:0]       hdr_r [HDR_BYTES];
  logic             hdr_we;
  logic [2:0]       hdr_idx;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [15:0]      start_r, start_nxt;
  logic [15:0]      count_r, count_nxt;
  logic [7:0]       fn_r, fn_nxt;

  logic             ovf_base;
  logic [CNT_W-1:0] cnt_base;
  logic [15:0]      crc_base;
  logic [31:0]      wait_inc;
  logic [7:0]       awaited_tick;
  logic [15:0]      sil_inc;
  logic [CNT_W-1:0] need;
  logic             is_read;

  assign q_pop      = q_valid && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_start_register = start_r;
  assign out_register_count = count_r;
  assign out_function_code  = fn_r;

  assign is_read = (hdr_r[1] == FN_READ_HOLDING) || (hdr_r[1] == FN_READ_INPUT);

  always_comb begin
    in_frame_nxt = in_frame_r;
    ovf_nxt      = ovf_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    sil_nxt      = sil_r;
    awaited_nxt  = awaited_r;
    wait_nxt     = wait_r;
    hdr_we       = 1'b0;
    hdr_idx      = cnt_r[2:0];
    status_nxt   = ST_IDLE;
    start_nxt    = '0;
    count_nxt    = '0;
    fn_nxt       = '0;

    ovf_base = in_frame_r ? ovf_r : 1'b0;
    cnt_base = in_frame_r ? cnt_r : '0;
    crc_base = in_frame_r ? crc_r : CRC_INIT;
    wait_inc = (wait_r == 32'hFFFF_FFFF) ? wait_r : wait_r + 32'd1;
    sil_inc  = (sil_r == 16'hFFFF) ? sil_r : sil_r + 16'd1;
    awaited_tick = awaited_r;
    if ((awaited_r != NODE_BROADCAST) && (wait_inc > timeout_r)) begin
      awaited_tick = NODE_BROADCAST;
    end
    need = (awaited_tick != NODE_BROADCAST) ? CNT_W'(7) : CNT_W'(8);

    case (q_item.op)
      OP_BYTE: begin
        in_frame_nxt = 1'b1;
        ovf_nxt      = ovf_base;
        cnt_nxt      = cnt_base;
        crc_nxt      = crc_base;
        hdr_idx      = cnt_base[2:0];
        if (!ovf_base) begin
          if (cnt_base >= CNT_W'(FRAME_BYTES)) begin
            ovf_nxt = 1'b1;
          end else begin
            hdr_we  = (cnt_base < CNT_W'(HDR_BYTES));
            crc_nxt = crc16_byte(crc_base, q_item.data);
            cnt_nxt = cnt_base + CNT_W'(1);
          end
        end
        sil_nxt    = '0;
        status_nxt = ST_RECV;
      end
      OP_TICK: begin
        if (awaited_r != NODE_BROADCAST) begin
          wait_nxt = wait_inc;
        end
        awaited_nxt = awaited_tick;
        if (!in_frame_r) begin
          status_nxt = ST_IDLE;
        end else begin
          sil_nxt = sil_inc;
          if (sil_inc < sil_limit_r) begin
            status_nxt = ST_RECV;
          end else begin
            in_frame_nxt = 1'b0;
            if (ovf_r) begin
              status_nxt = ST_OVF;
            end else if (cnt_r < need) begin
              awaited_nxt = NODE_BROADCAST;
              status_nxt  = ST_BAD_LEN;
            end else if (crc_r != 16'h0000) begin
              awaited_nxt = NODE_BROADCAST;
              status_nxt  = ST_CRC_BAD;
            end else if ((awaited_tick == NODE_BROADCAST) && (hdr_r[0] == own_addr_r)) begin
              fn_nxt = hdr_r[1];
              if (is_read) begin
                status_nxt = ST_REQ_OK;
                start_nxt  = {hdr_r[2], hdr_r[3]};
                count_nxt  = {hdr_r[4], hdr_r[5]};
              end else begin
                status_nxt = ST_ILL_FN;
              end
            end else if ((awaited_tick != NODE_BROADCAST) && (hdr_r[0] == awaited_tick)) begin
              awaited_nxt = NODE_BROADCAST;
              status_nxt  = is_read ? ST_REPLY_OK : ST_REPLY_ERR;
            end else begin
              status_nxt = ST_IDLE;
            end
          end
        end
      end
      OP_REQ: begin
        if (!q_item.node_ok || in_frame_r || (awaited_r != NODE_BROADCAST)) begin
          status_nxt = ST_REFUSE;
        end else begin
          in_frame_nxt = 1'b0;
          ovf_nxt      = 1'b0;
          cnt_nxt      = '0;
          crc_nxt      = CRC_INIT;
          sil_nxt      = '0;
          awaited_nxt  = q_item.data;
          wait_nxt     = '0;
          status_nxt   = ST_ACCEPT;
        end
      end
      default: begin
        status_nxt = in_frame_r ? ST_RECV : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= OWN_ADDR_RST;
      sil_limit_r <= SILENCE_LIMIT_RST;
      timeout_r   <= REPLY_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDR:      own_addr_r  <= cfg_wdata[7:0];
        CFG_SILENCE_LIMIT: sil_limit_r <= cfg_wdata[15:0];
        CFG_REPLY_TIMEOUT: timeout_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= CRC_INIT;
      sil_r       <= '0;
      awaited_r   <= NODE_BROADCAST;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        in_frame_r <= in_frame_nxt;
        ovf_r      <= ovf_nxt;
        cnt_r      <= cnt_nxt;
        crc_r      <= crc_nxt;
        sil_r      <= sil_nxt;
        awaited_r  <= awaited_nxt;
        wait_r     <= wait_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      fn_r     <= fn_nxt;
    end
    if (q_pop && hdr_we) begin
      hdr_r[hdr_idx] <= q_item.data;
    end
  end

endmodule

`default_nettype wire

### sv/modbus_rtu_frame_receiver_unit.sv
// ---------------------------------------------------------------------------
// modbus_rtu_frame_receiver_unit
// modbus rtu frame receiver with crc-16 check, slave and master paths
// ---------------------------------------------------------------------------
// in_* carries one item per handshake: a received byte, a one-microsecond
// tick or a master request notice (selected by in_tuser). every item gives
// exactly one result item on out_*: a status in out_tuser, function code for
// a request to own address, and start register and register count for a good read.
// cfg_we/cfg_index/cfg_wdata write own address, silence limit and reply
// timeout; write them only while no item is in flight.
// with an empty queue, a taken item passes the queue slot and then the result
// register, which raises out_tvalid and holds the result until it is taken.
// throughput: one item per cycle while out_tready is high, set by the crc
// and close step (combinational in the back end); a four-item queue sits
// between accept and execute. the input keeps accepting while a result
// waits, until the queue is full; a stalled out_tready holds the result and
// backs up into the queue. reset (rst_n low, synchronous) empties the queue,
// closes any frame, drops any awaited reply and restores the register
// defaults; the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_frame_receiver_unit #(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // rx_byte, target_node
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // start_register, register_count, function_code
  output logic [3:0]       out_tuser   // status
);
  import mrfr_pkg::*;

  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  status_t     status;
  logic [15:0] start_register;
  logic [15:0] register_count;
  logic [7:0]  function_code;

  mrfr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_kind        (in_tuser),
    .in_rx_byte     (in_tdata[7:0]),
    .in_target_node (in_tdata[15:8]),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  mrfr_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_status         (status),
    .out_start_register (start_register),
    .out_register_count (register_count),
    .out_function_code  (function_code)
  );

  assign out_tuser = status;
  assign out_tdata = {function_code, register_count, start_register};

endmodule

`default_nettype wire

### sv/mrfr_checker.sv
// ---------------------------------------------------------------------------
// mrfr_checker
// port-level checks on the result channel, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_frame_receiver_unit_defines.svh"

module mrfr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [3:0]  out_tuser
);
  import mrfr_pkg::*;

  logic       st_legal;
  logic       st_req_ok;
  logic       has_fn;
  logic       zero_data;
  logic       fn_is_read;
  logic       stalled;
  logic [7:0] fn_code;
  logic [43:0] out_item;

  assign st_legal   = (out_tuser <= ST_REFUSE);
  assign st_req_ok  = (out_tuser == ST_REQ_OK);
  assign has_fn     = st_req_ok || (out_tuser == ST_ILL_FN);
  assign zero_data  = (out_tdata == '0);
  assign fn_code    = out_tdata[39:32];
  assign fn_is_read = (fn_code == FN_READ_HOLDING) || (fn_code == FN_READ_INPUT);
  assign stalled    = out_tvalid && !out_tready;
  assign out_item   = {out_tuser, out_tdata};

  `MRFR_ASSERT_NOW(a_status_range, clk, rst_n, out_tvalid, st_legal, "bad status")

  `MRFR_ASSERT_NOW(a_fields_zero, clk, rst_n, out_tvalid && !has_fn, zero_data, "fields set")

  `MRFR_ASSERT_NOW(a_fn_match, clk, rst_n, out_tvalid && st_req_ok, fn_is_read, "bad function")

  `MRFR_ASSERT_NEXT(a_hold, clk, rst_n, stalled, out_tvalid && $stable(out_item), "stall broken")

endmodule

bind modbus_rtu_frame_receiver_unit mrfr_checker u_mrfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### bench/modbus_rx_check_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus rx checking package
// expected-result tracking for the modbus rtu frame receiver: mirrors the
// receive, silence, crc and reply-wait state and compares every result item
// ---------------------------------------------------------------------------

package modbus_rx_check_pkg;
  import mrfr_pkg::*;

  localparam int FRAME_LEN  = 64;
  localparam int REPORT_MAX = 10;

  typedef struct {
    status_t     status;
    logic [15:0] start_reg;
    logic [15:0] reg_count;
    logic [7:0]  fn_code;
  } rx_result_t;

  // reflected crc-16, one byte shifted in lsb first
  function automatic logic [15:0] crc_shift_in(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  class rx_frame_scoreboard;
    logic [7:0]  own_addr;
    logic [15:0] silence_lim;
    logic [31:0] reply_tmo;
    bit          in_frame;
    bit          overflowed;
    int unsigned byte_cnt;
    logic [15:0] crc;
    logic [7:0]  hdr [6];
    logic [15:0] silence_cnt;
    logic [7:0]  awaited;
    logic [31:0] wait_cnt;
    rx_result_t  expected_q [$];
    int unsigned mismatches;

    function new();
      reset_state();
    endfunction

    function void clear_rx();
      in_frame    = 1'b0;
      overflowed  = 1'b0;
      byte_cnt    = 0;
      crc         = CRC_INIT;
      silence_cnt = '0;
    endfunction

    function void reset_state();
      own_addr    = OWN_ADDR_RST;
      silence_lim = SILENCE_LIMIT_RST;
      reply_tmo   = REPLY_TIMEOUT_RST;
      clear_rx();
      foreach (hdr[i]) hdr[i] = 8'h00;
      awaited    = 8'h00;
      wait_cnt   = '0;
      mismatches = 0;
      expected_q.delete();
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
        CFG_OWN_ADDR:      own_addr    = value[7:0];
        CFG_SILENCE_LIMIT: silence_lim = value[15:0];
        CFG_REPLY_TIMEOUT: reply_tmo   = value;
        default: ;
      endcase
    endfunction

    function bit is_read_fn(input logic [7:0] fn);
      return fn == FN_READ_HOLDING || fn == FN_READ_INPUT;
    endfunction

    function rx_result_t close_frame();
      rx_result_t  r;
      bit          waiting;
      int unsigned need;
      logic [7:0]  fn;
      r.status    = ST_IDLE;
      r.start_reg = '0;
      r.reg_count = '0;
      r.fn_code   = '0;
      waiting     = awaited != 8'h00;
      need        = waiting ? 7 : 8;
      fn          = hdr[1];
      in_frame    = 1'b0;
      if (overflowed) begin
        r.status = ST_OVF;
      end else if (byte_cnt < need) begin
        awaited  = 8'h00;
        r.status = ST_BAD_LEN;
      end else if (crc != 16'h0000) begin
        awaited  = 8'h00;
        r.status = ST_CRC_BAD;
      end else if (!waiting && hdr[0] == own_addr) begin
        r.fn_code = fn;
        if (is_read_fn(fn)) begin
          r.status    = ST_REQ_OK;
          r.start_reg = {hdr[2], hdr[3]};
          r.reg_count = {hdr[4], hdr[5]};
        end else begin
          r.status = ST_ILL_FN;
        end
      end else if (waiting && hdr[0] == awaited) begin
        awaited  = 8'h00;
        r.status = is_read_fn(fn) ? ST_REPLY_OK : ST_REPLY_ERR;
      end
      return r;
    endfunction

    // one accepted item, one expected result item
    function void note_item(input op_t kind, input logic [7:0] rx, input logic [7:0] node);
      rx_result_t r;
      r.status    = ST_IDLE;
      r.start_reg = '0;
      r.reg_count = '0;
      r.fn_code   = '0;
      case (kind)
        OP_BYTE: begin
          if (!in_frame) begin
            clear_rx();
            in_frame = 1'b1;
          end
          if (!overflowed) begin
            if (byte_cnt >= FRAME_LEN) begin
              overflowed = 1'b1;
            end else begin
              if (byte_cnt < HDR_BYTES) hdr[byte_cnt] = rx;
              crc      = crc_shift_in(crc, rx);
              byte_cnt = byte_cnt + 1;
            end
          end
          silence_cnt = '0;
          r.status    = ST_RECV;
        end
        OP_TICK: begin
          if (awaited != 8'h00) begin
            if (wait_cnt != 32'hFFFF_FFFF) wait_cnt = wait_cnt + 1;
            if (wait_cnt > reply_tmo) awaited = 8'h00;
          end
          if (in_frame) begin
            if (silence_cnt != 16'hFFFF) silence_cnt = silence_cnt + 16'd1;
            if (silence_cnt < silence_lim) r.status = ST_RECV;
            else r = close_frame();
          end
        end
        OP_REQ: begin
          if (node == NODE_BROADCAST || node == NODE_RESERVED || in_frame ||
              awaited != 8'h00) begin
            r.status = ST_REFUSE;
          end else begin
            clear_rx();
            awaited  = node;
            wait_cnt = '0;
            r.status = ST_ACCEPT;
          end
        end
        default: begin
          r.status = in_frame ? ST_RECV : ST_IDLE;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic [3:0] st, input logic [39:0] data);
      rx_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result item: status %0d data %h", st, data);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || data[15:0] !== e.start_reg || data[31:16] !== e.reg_count ||
          data[39:32] !== e.fn_code) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result mismatch: exp status %0d start %h count %h fn %h / got status %0d start %h count %h fn %h",
                   e.status, e.start_reg, e.reg_count, e.fn_code,
                   st, data[15:0], data[31:16], data[39:32]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus rtu frame receiver testbench
// drives bytes, ticks, no-ops and master request notices through the stream
// ports, rewrites the address, silence and timeout registers between runs and
// checks every result item against a mirrored receiver, under random stalls
// ---------------------------------------------------------------------------

module testbench;
  import mrfr_pkg::*;
  import modbus_rx_check_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // rx_byte, target_node
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // start_register, register_count, function_code
  logic [3:0]  out_tuser;  // status

  rx_frame_scoreboard sb;
  int unsigned snd_idle_pct = 6;
  int unsigned rcv_idle_pct = 77;
  int unsigned items_sent   = 0;
  int unsigned hold_asked   = 0;
  int unsigned hold_done    = 0;
  int unsigned hold_left    = 0;
  logic [7:0]  cur_own;
  int unsigned cur_sil;
  logic [31:0] cur_tmo;
  logic [7:0]  frame_buf [$];

  modbus_rtu_frame_receiver_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: check, then random or long hold-off on tready
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_done) begin
      hold_done  = hold_done + 1;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_item(input op_t kind, input logic [7:0] rx, input logic [7:0] node);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {node, rx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(kind, rx, node);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  // appends the crc to frame_buf, optionally flips one bit, sends the bytes
  task automatic send_buf(input bit corrupt);
    logic [15:0] c;
    int unsigned k;
    c = CRC_INIT;
    foreach (frame_buf[i]) c = crc_shift_in(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    if (corrupt) begin
      k = $urandom_range(frame_buf.size() - 1);
      frame_buf[k] = frame_buf[k] ^ (8'd1 << $urandom_range(7));
    end
    foreach (frame_buf[i]) send_item(OP_BYTE, frame_buf[i], 8'($urandom));
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fn,
                            input int unsigned body_len, input bit corrupt);
    frame_buf = {addr, fn};
    repeat (body_len) frame_buf.push_back(8'($urandom));
    send_buf(corrupt);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] own, input logic [15:0] sil,
                            input logic [31:0] tmo);
    drain();
    write_reg(CFG_OWN_ADDR, {24'h0, own});
    write_reg(CFG_SILENCE_LIMIT, {16'h0, sil});
    write_reg(CFG_REPLY_TIMEOUT, tmo);
    cur_own = own;
    cur_sil = 32'(sil);
    cur_tmo = tmo;
  endtask

  function automatic logic [7:0] pick_fn();
    case ($urandom_range(3))
      0:       return 8'($urandom);
      1:       return FN_READ_INPUT;
      default: return FN_READ_HOLDING;
    endcase
  endfunction

  task automatic directed_checks();
    send_item(OP_NOP, 8'hFF, 8'hFF);
    send_item(OP_TICK, 8'h00, 8'h00);
    // read request at the reset address, closed after a shorter silence limit
    frame_buf = {cur_own, FN_READ_INPUT, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_buf(1'b0);
    send_item(OP_NOP, 8'h00, 8'h00);
    set_config(cur_own, 16'd2, cur_tmo);
    send_ticks(cur_sil);
    send_item(OP_REQ, 8'h00, NODE_BROADCAST);
    send_item(OP_REQ, 8'h00, NODE_RESERVED);
    send_item(OP_REQ, 8'hFF, 8'hFE);
    send_item(OP_REQ, 8'h00, 8'h01);
    // zero timeout and zero silence limit
    set_config(8'h00, 16'h0000, 32'h0000_0000);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'h00, 8'h00);
    send_item(OP_TICK, 8'hFF, 8'hFF);
    frame_buf = {8'h00, FN_READ_HOLDING, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_buf(1'b0);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_REQ, 8'h00, 8'h07);
    send_item(OP_TICK, 8'h00, 8'h00);
    // top address, longest silence and timeout
    set_config(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    frame_buf = {8'hFF, FN_READ_HOLDING, 8'h12, 8'h34, 8'h00, 8'h7D};
    send_buf(1'b0);
    send_ticks(4);
    send_item(OP_REQ, 8'h55, 8'h09);
    set_config(8'hFF, 16'h0001, 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_REQ, 8'h00, 8'h14);
    frame_buf = {8'h14, FN_READ_INPUT, 8'h02, 8'hAB, 8'hCD};
    send_buf(1'b0);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_REQ, 8'h00, 8'h14);
    frame_buf = {8'h14, 8'h83, 8'h02, 8'h00, 8'h00};
    send_buf(1'b0);
    send_item(OP_TICK, 8'h00, 8'h00);
    frame_buf = {8'hFF, 8'h10, 8'h00, 8'h01, 8'h00, 8'h02};
    send_buf(1'b0);
    send_item(OP_TICK, 8'h00, 8'h00);
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned goal;
    logic [7:0]  node;
    logic [7:0]  addr;
    goal = items_sent + n;
    while (items_sent < goal) begin
      case ($urandom_range(15))
        0, 1, 2, 3, 4: begin
          addr = ($urandom_range(3) != 0) ? cur_own : 8'($urandom);
          send_frame(addr, pick_fn(), 4, $urandom_range(7) == 0);
          send_ticks(cur_sil + $urandom_range(2));
        end
        5, 6, 7, 8, 9: begin
          if ($urandom_range(15) == 0) node = $urandom_range(1) ? NODE_BROADCAST : NODE_RESERVED;
          else node = 8'($urandom_range(1, 254));
          send_item(OP_REQ, 8'($urandom), node);
          if ($urandom_range(3) == 0) send_ticks($urandom_range(5));
          if ($urandom_range(5) == 0) begin
            send_ticks((cur_tmo < 64) ? cur_tmo + 1 : 3);
          end else begin
            addr = ($urandom_range(5) != 0) ? node : 8'($urandom);
            send_frame(addr, pick_fn(), ($urandom_range(3) != 0) ? 3 : 4,
                       $urandom_range(9) == 0);
            send_ticks(cur_sil);
          end
        end
        10, 11: begin
          repeat ($urandom_range(1, 8))
            send_item(op_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
        end
        12: begin
          repeat ($urandom_range(1, 7)) send_item(OP_BYTE, 8'($urandom), 8'($urandom));
          send_ticks(cur_sil);
        end
        13: begin
          send_frame(cur_own, pick_fn(), $urandom_range(60, 68), 1'b0);
          send_ticks(cur_sil);
        end
        default: begin
          send_frame(cur_own, pick_fn(), $urandom_range(8), $urandom_range(5) == 0);
          send_ticks(cur_sil);
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0]  own;
    logic [31:0] tmo;
    sb         = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_OWN_ADDR;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_BYTE;
    out_tready = 1'b0;
    cur_own    = OWN_ADDR_RST;
    cur_sil    = 32'(SILENCE_LIMIT_RST);
    cur_tmo    = REPLY_TIMEOUT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    for (int phase = 0; phase < 3; phase++) begin
      for (int part = 0; part < 4; part++) begin
        case ($urandom_range(3))
          0:       own = 8'h00;
          1:       own = 8'hFF;
          default: own = 8'($urandom);
        endcase
        case ($urandom_range(4))
          0:       tmo = 32'hFFFF_FFFF;
          1:       tmo = 32'd1;
          default: tmo = $urandom_range(4, 40);
        endcase
        set_config(own, 16'($urandom_range(1, 6)), tmo);
        // idling pattern changes per phase
        case (phase)
          0: begin
            snd_idle_pct = 6;
            rcv_idle_pct = 77;
          end
          1: begin
            snd_idle_pct = 77;
            rcv_idle_pct = 6;
          end
          default: begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
          end
        endcase
        if (phase == 2 && part != 0) hold_asked++;
        run_traffic(32);
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
